@@ rtl/core/stb_pkg.sv @@
// Types and constants shared by the timer bank modules.
// Depends on nothing.
package stb_pkg;

    localparam logic [2:0] KIND_TICK       = 3'd0;
    localparam logic [2:0] KIND_INIT       = 3'd1;
    localparam logic [2:0] KIND_ON_OFF     = 3'd2;
    localparam logic [2:0] KIND_RESTART    = 3'd3;
    localparam logic [2:0] KIND_SET_PERIOD = 3'd4;
    localparam logic [2:0] KIND_POLL       = 3'd5;

    localparam int TICK_W = 10;
    localparam int CNT_W  = 32;

    typedef struct packed {
        logic [2:0]       kind;
        logic [3:0]       timer_index;
        logic [CNT_W-1:0] period_len;
        logic             auto_reload;
        logic             notify_enable;
        logic             run_enable;
    } in_item_t;

    typedef struct packed {
        logic       event_valid;
        logic [3:0] event_index;
        logic       timed_out;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [2:0]       kind;
        logic [3:0]       timer_index;
        logic             in_range;
        logic             apply;
        logic [CNT_W-1:0] ticks;
        logic             auto_reload;
        logic             notify_enable;
        logic             run_enable;
    } cmd_t;

endpackage

@@ rtl/core/soft_timer_bank.sv @@
// Top level of the countdown timer bank: configuration register and the
// front end, command queue and back end. Depends on stb_pkg, stb_front,
// stb_fifo and stb_back.
//
// Usage: the tick length in ms is written over the APB-style port at
// address 0 while the block is idle; reads return it. Items enter on
// in_valid/in_ready and results leave on out_valid/out_ready, each result
// carrying last on the final one of its item.
// An init or set-period item for an in-range timer, with a nonzero tick
// length and, for set-period, a nonzero period, goes through the front
// end's bit-serial divider, one quotient bit a cycle; other items pass the
// front undivided. A tick walks the timer state one entry a cycle, save for
// the pause below, with both back end memories read at one shared address.
// The two-entry queue lets the front accept and divide the next item while
// the back end is still busy.
// Reset clears all timer flags, the tick length and all queues; counts are
// undefined until an init writes them. A stalled receiver holds the result
// register, and the tick walk pauses when a second event is waiting.
module soft_timer_bank
    import stb_pkg::*;
#(
    parameter int NUM_TIMERS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_item
);

    logic [TICK_W-1:0] tick_reg, tick_next;
    logic              push_valid, push_ready, pop_valid, pop_ready;
    cmd_t              push_data, pop_data;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {{(32-TICK_W){1'b0}}, tick_reg};

    always_comb
    begin
        tick_next = tick_reg;
        if (psel && penable && pwrite && !paddr[2])
        begin
            tick_next = pwdata[TICK_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg <= '0;
        end
        else
        begin
            tick_reg <= tick_next;
        end
    end

    stb_front #(.NUM_TIMERS(NUM_TIMERS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_ms    (tick_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    stb_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    stb_back #(.NUM_TIMERS(NUM_TIMERS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

@@ rtl/core/stb_front.sv @@
// Front end: accepts items, checks them and converts periods to ticks.
// Depends on stb_pkg.
module stb_front
    import stb_pkg::*;
#(
    parameter int NUM_TIMERS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [TICK_W-1:0] tick_ms,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_item_t          in_item,
    output logic              push_valid,
    input  logic              push_ready,
    output cmd_t              push_data
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DIV  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]       state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [CNT_W-1:0] quot_reg, quot_next;
    logic [TICK_W-1:0] rem_reg, rem_next;
    logic [4:0]       cnt_reg, cnt_next;

    logic              in_range;
    logic              tick_ok;
    logic              needs_div;
    logic [TICK_W:0]   shifted;
    logic              ge;
    logic [TICK_W:0]   diff;

    assign in_range  = {3'b000, in_item.timer_index} < 7'(NUM_TIMERS);
    assign tick_ok   = tick_ms != '0;
    assign needs_div = in_range && tick_ok &&
                       ((in_item.kind == KIND_INIT) ||
                        ((in_item.kind == KIND_SET_PERIOD) && (in_item.period_len != '0)));
    assign shifted   = {rem_reg, quot_reg[CNT_W-1]};
    assign ge        = shifted >= {1'b0, tick_ms};
    assign diff      = shifted - {1'b0, tick_ms};

    assign in_ready   = state_reg == F_IDLE;
    assign push_valid = state_reg == F_PUSH;

    always_comb
    begin
        push_data       = cmd_reg;
        push_data.ticks = quot_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next.kind          = in_item.kind;
                    cmd_next.timer_index   = in_item.timer_index;
                    cmd_next.in_range      = in_range;
                    cmd_next.apply         = needs_div;
                    cmd_next.ticks         = in_item.period_len;
                    cmd_next.auto_reload   = in_item.auto_reload;
                    cmd_next.notify_enable = in_item.notify_enable;
                    cmd_next.run_enable    = in_item.run_enable;
                    quot_next = in_item.period_len;
                    rem_next  = '0;
                    cnt_next  = '0;
                    state_next = needs_div ? F_DIV : F_PUSH;
                end
            end
            F_DIV:
            begin
                quot_next = {quot_reg[CNT_W-2:0], ge};
                rem_next  = ge ? diff[TICK_W-1:0] : shifted[TICK_W-1:0];
                cnt_next  = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
    end

endmodule

@@ rtl/core/stb_fifo.sv @@
// Two-entry command queue between front and back end.
// Depends on stb_pkg.
module stb_fifo
    import stb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_data
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = count_reg != 2'd2;
    assign pop_valid  = count_reg != 2'd0;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/core/stb_back.sv @@
// Back end: timer state, tick walk and result register.
// Depends on stb_pkg.
module stb_back
    import stb_pkg::*;
#(
    parameter int NUM_TIMERS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pop_valid,
    output logic      pop_ready,
    input  cmd_t      pop_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    localparam int TW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [TW-1:0] LAST_IDX = TW'(NUM_TIMERS - 1);

    localparam logic [1:0] B_IDLE  = 2'd0;
    localparam logic [1:0] B_CMD   = 2'd1;
    localparam logic [1:0] B_WALK  = 2'd2;
    localparam logic [1:0] B_FLUSH = 2'd3;

    logic [1:0]            state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [TW-1:0]         idx_reg, idx_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [TW-1:0]         pend_idx_reg, pend_idx_next;
    logic [NUM_TIMERS-1:0] registered_reg, registered_next;
    logic [NUM_TIMERS-1:0] running_reg, running_next;
    logic [NUM_TIMERS-1:0] flag_reg, flag_next;
    logic [NUM_TIMERS-1:0] reload_reg, reload_next;
    logic [NUM_TIMERS-1:0] notify_reg, notify_next;
    logic                  out_valid_reg, out_valid_next;
    out_item_t             out_item_reg, out_item_next;

    logic [CNT_W-1:0] rem_mem [NUM_TIMERS];
    logic [CNT_W-1:0] rel_mem [NUM_TIMERS];
    logic [CNT_W-1:0] rem_rd_reg;
    logic [CNT_W-1:0] rel_rd_reg;
    logic             rem_we, rel_we;
    logic [TW-1:0]    wr_addr, rd_addr;
    logic [CNT_W-1:0] rem_wd, rel_wd;

    logic             slot_free;
    logic             push_out;
    out_item_t        push_item;
    logic [TW-1:0]    t;
    logic             active, expired, ev, advance;
    logic [CNT_W-1:0] dec;

    assign slot_free = !out_valid_reg || out_ready;
    assign pop_ready = state_reg == B_IDLE;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign t         = TW'(cmd_reg.timer_index);

    assign active  = registered_reg[idx_reg] && running_reg[idx_reg];
    assign dec     = rem_rd_reg - 32'd1;
    assign expired = active && (dec == '0);
    assign ev      = expired && notify_reg[idx_reg];
    assign advance = !(ev && pend_valid_reg) || slot_free;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        registered_next = registered_reg;
        running_next    = running_reg;
        flag_next       = flag_reg;
        reload_next     = reload_reg;
        notify_next     = notify_reg;
        rem_we    = 1'b0;
        rel_we    = 1'b0;
        wr_addr   = t;
        rem_wd    = cmd_reg.ticks;
        rel_wd    = cmd_reg.ticks;
        rd_addr   = idx_reg;
        push_out  = 1'b0;
        push_item = '0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (pop_valid)
                begin
                    cmd_next = pop_data;
                    if (pop_data.kind == KIND_TICK)
                    begin
                        idx_next        = '0;
                        pend_valid_next = 1'b0;
                        rd_addr         = '0;
                        state_next      = B_WALK;
                    end
                    else
                    begin
                        rd_addr    = TW'(pop_data.timer_index);
                        state_next = B_CMD;
                    end
                end
            end
            B_CMD:
            begin
                rd_addr = t;
                if (slot_free)
                begin
                    push_out       = 1'b1;
                    push_item.last = 1'b1;
                    if (cmd_reg.in_range)
                    begin
                        unique case (cmd_reg.kind)
                            KIND_INIT:
                            begin
                                if (cmd_reg.apply && !registered_reg[t])
                                begin
                                    registered_next[t] = 1'b1;
                                    running_next[t]    = 1'b0;
                                    flag_next[t]       = 1'b0;
                                    reload_next[t]     = cmd_reg.auto_reload;
                                    notify_next[t]     = cmd_reg.notify_enable;
                                    rem_we = 1'b1;
                                    rel_we = 1'b1;
                                end
                            end
                            KIND_ON_OFF:
                            begin
                                running_next[t] = cmd_reg.run_enable;
                            end
                            KIND_RESTART:
                            begin
                                flag_next[t]    = 1'b0;
                                running_next[t] = 1'b1;
                                rem_wd = rel_rd_reg;
                                rem_we = 1'b1;
                            end
                            KIND_SET_PERIOD:
                            begin
                                rem_we = cmd_reg.apply;
                                rel_we = cmd_reg.apply;
                            end
                            KIND_POLL:
                            begin
                                push_item.timed_out = flag_reg[t];
                                flag_next[t]        = 1'b0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    state_next = B_IDLE;
                end
            end
            B_WALK:
            begin
                if (advance)
                begin
                    rd_addr = (idx_reg == LAST_IDX) ? '0 : idx_reg + TW'(1);
                    wr_addr = idx_reg;
                    rem_wd  = (expired && reload_reg[idx_reg]) ? rel_rd_reg : dec;
                    rem_we  = active;
                    if (expired)
                    begin
                        flag_next[idx_reg] = !notify_reg[idx_reg];
                        if (!reload_reg[idx_reg])
                        begin
                            running_next[idx_reg] = 1'b0;
                        end
                    end
                    if (ev)
                    begin
                        if (pend_valid_reg)
                        begin
                            push_out              = 1'b1;
                            push_item.event_valid = 1'b1;
                            push_item.event_index = 4'(pend_idx_reg);
                        end
                        pend_valid_next = 1'b1;
                        pend_idx_next   = idx_reg;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = B_FLUSH;
                    end
                    else
                    begin
                        idx_next = idx_reg + TW'(1);
                    end
                end
            end
            B_FLUSH:
            begin
                if (slot_free)
                begin
                    push_out              = 1'b1;
                    push_item.last        = 1'b1;
                    push_item.event_valid = pend_valid_reg;
                    push_item.event_index = pend_valid_reg ? 4'(pend_idx_reg) : 4'd0;
                    pend_valid_next       = 1'b0;
                    state_next            = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_item_next = out_item_reg;
        if (push_out)
        begin
            out_valid_next = 1'b1;
            out_item_next  = push_item;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            pend_valid_reg <= 1'b0;
            registered_reg <= '0;
            running_reg    <= '0;
            flag_reg       <= '0;
            reload_reg     <= '0;
            notify_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            registered_reg <= registered_next;
            running_reg    <= running_next;
            flag_reg       <= flag_next;
            reload_reg     <= reload_next;
            notify_reg     <= notify_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        idx_reg      <= idx_next;
        pend_idx_reg <= pend_idx_next;
        out_item_reg <= out_item_next;
    end

    always_ff @(posedge clk)
    begin
        if (rem_we)
        begin
            rem_mem[wr_addr] <= rem_wd;
        end
        if (rel_we)
        begin
            rel_mem[wr_addr] <= rel_wd;
        end
        rem_rd_reg <= rem_mem[rd_addr];
        rel_rd_reg <= rel_mem[rd_addr];
    end

endmodule
